// ===== design/mmq_pkg.sv =====
// mmq_pkg: shared sizes, types, microcode program and codes of the
// min/max uniform quantizer. No dependencies.
`timescale 1ns / 1ps

package mmq_pkg;

    // Sample format and derived widths
    localparam int SAMPLE_W    = 16;
    localparam int MAX_LEVELS  = 256;
    localparam int LEVEL_W     = 9;                    // levels register
    localparam int IDX_W       = 8;                    // level index
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;
    localparam int RANGE_W     = SAMPLE_W + 1;         // max - min, x - min
    localparam int PROD_W      = RANGE_W + LEVEL_W;    // shared multiplier
    localparam int NUM_W       = PROD_W + 1;           // divider numerator
    localparam int DEN_W       = RANGE_W + 1;          // divider denominator
    localparam int QUOT_W      = RANGE_W;              // quotient bits = steps
    localparam int DCNT_W      = $clog2(QUOT_W + 1);
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((IDX_W + SAMPLE_W + 7) / 8) * 8;
    localparam int UPC_W       = 4;

    localparam logic [LEVEL_W-1:0] LEVELS_RESET = LEVEL_W'(MAX_LEVELS);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FLAT    = 2'd2;

    // Input op codes
    localparam logic OP_MEASURE  = 1'b0;
    localparam logic OP_QUANTIZE = 1'b1;

    // Datapath action of one microcode step
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_MEASURE,
        ACT_PREP,
        ACT_MUL_DL,
        ACT_DIV_IDX,
        ACT_DIV_STEP,
        ACT_IDX_Q,
        ACT_MUL_IR,
        ACT_DIV_OFF,
        ACT_WRITE
    } mmq_action_t;

    // Jump condition: taken -> target, else next step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_QUANT,
        COND_SPECIAL,
        COND_EDGE,
        COND_DIV_MORE,
        COND_OUT_FULL
    } mmq_cond_t;

    typedef struct packed {
        mmq_action_t      action;
        mmq_cond_t        cond;
        logic [UPC_W-1:0] target;
    } mmq_uword_t;

    // Control from sequencer to datapath
    typedef struct packed {
        mmq_action_t action;
    } mmq_ctrl_t;

    // Condition flags from datapath to sequencer
    typedef struct packed {
        logic no_input;
        logic quant;
        logic special;
        logic edge_case;
        logic div_more;
        logic out_full;
    } mmq_flags_t;

    // Step addresses
    localparam logic [UPC_W-1:0] UA_FETCH   = 4'd0;
    localparam logic [UPC_W-1:0] UA_PREP    = 4'd3;
    localparam logic [UPC_W-1:0] UA_DIV1    = 4'd7;
    localparam logic [UPC_W-1:0] UA_MUL_IR  = 4'd9;
    localparam logic [UPC_W-1:0] UA_DIV2    = 4'd11;
    localparam logic [UPC_W-1:0] UA_WRITE   = 4'd12;

    // Microcode program
    function automatic mmq_uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        mmq_uword_t w;
        unique case (addr)
            4'd0:    w = '{ACT_ACCEPT,   COND_NO_INPUT, UA_FETCH};
            4'd1:    w = '{ACT_NONE,     COND_QUANT,    UA_PREP};
            4'd2:    w = '{ACT_MEASURE,  COND_ALWAYS,   UA_FETCH};
            4'd3:    w = '{ACT_PREP,     COND_NEVER,    UA_FETCH};
            4'd4:    w = '{ACT_MUL_DL,   COND_SPECIAL,  UA_WRITE};
            4'd5:    w = '{ACT_NONE,     COND_EDGE,     UA_MUL_IR};
            4'd6:    w = '{ACT_DIV_IDX,  COND_NEVER,    UA_FETCH};
            4'd7:    w = '{ACT_DIV_STEP, COND_DIV_MORE, UA_DIV1};
            4'd8:    w = '{ACT_IDX_Q,    COND_NEVER,    UA_FETCH};
            4'd9:    w = '{ACT_MUL_IR,   COND_NEVER,    UA_FETCH};
            4'd10:   w = '{ACT_DIV_OFF,  COND_NEVER,    UA_FETCH};
            4'd11:   w = '{ACT_DIV_STEP, COND_DIV_MORE, UA_DIV2};
            4'd12:   w = '{ACT_WRITE,    COND_OUT_FULL, UA_WRITE};
            default: w = '{ACT_NONE,     COND_ALWAYS,   UA_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== design/mmq_sequencer.sv =====
// mmq_sequencer: step counter and microcode ROM; issues one control word
// per cycle. Depends on mmq_pkg.
`timescale 1ns / 1ps

module mmq_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  mmq_pkg::mmq_flags_t flags,
    output mmq_pkg::mmq_ctrl_t  ctrl
);
    import mmq_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    mmq_uword_t       uword;
    logic             taken;

    assign uword       = ucode_rom(upc_reg);
    assign ctrl.action = uword.action;

    // Jump condition select
    always_comb begin
        unique case (uword.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_NO_INPUT: taken = flags.no_input;
            COND_QUANT:    taken = flags.quant;
            COND_SPECIAL:  taken = flags.special;
            COND_EDGE:     taken = flags.edge_case;
            COND_DIV_MORE: taken = flags.div_more;
            COND_OUT_FULL: taken = flags.out_full;
            default:       taken = 1'b1;
        endcase
        upc_next = taken ? uword.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== design/mmq_divider.sv =====
// mmq_divider: restoring radix-2 divider, one quotient bit per step.
// The quotient must fit QUOT_W bits. Depends on mmq_pkg.
`timescale 1ns / 1ps

module mmq_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       step,
    input  logic [mmq_pkg::NUM_W-1:0]  num,
    input  logic [mmq_pkg::DEN_W-1:0]  den,
    output logic [mmq_pkg::QUOT_W-1:0] quot,
    output logic                       more
);
    import mmq_pkg::*;

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] nq_reg;     // numerator bits out, quotient bits in
    logic [QUOT_W-1:0] nq_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              qbit;

    // One trial subtraction
    always_comb begin
        trial    = {rem_reg, nq_reg[QUOT_W-1]};
        diff     = trial - {1'b0, den_reg};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_next  = {nq_reg[QUOT_W-2:0], qbit};
    end

    assign quot = nq_reg;
    assign more = (cnt_reg != DCNT_W'(1));

    // Operand and partial remainder registers
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num[NUM_W-1:QUOT_W]);
            nq_reg  <= num[QUOT_W-1:0];
            den_reg <= den;
        end else if (step) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DCNT_W'(QUOT_W);
        end else if (step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== design/mmq_datapath.sv =====
// mmq_datapath: input, min/max/count, levels and result registers, the
// shared multiplier and the divider. Depends on mmq_pkg, mmq_divider.
`timescale 1ns / 1ps

module mmq_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mmq_pkg::mmq_ctrl_t              ctrl,
    output mmq_pkg::mmq_flags_t             flags,
    input  logic                            in_valid,
    input  logic                            in_op,
    input  logic                            in_first,
    input  logic [mmq_pkg::SAMPLE_W-1:0]    in_sample,
    input  logic                            cfg_we,
    input  logic [mmq_pkg::LEVEL_W-1:0]     cfg_levels,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mmq_pkg::IDX_W-1:0]       out_index,
    output logic [mmq_pkg::SAMPLE_W-1:0]    out_value,
    output logic [mmq_pkg::STATUS_W-1:0]    out_status
);
    import mmq_pkg::*;

    logic                op_reg;
    logic                first_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [LEVEL_W-1:0]  levels_reg;
    logic [RANGE_W-1:0]  range_reg;
    logic [RANGE_W-1:0]  diff_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                special_reg;
    logic                edge_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic [SAMPLE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [LEVEL_W-1:0]  lvl;
    logic [LEVEL_W-1:0]  lvl_m1;
    logic [RANGE_W-1:0]  diff_w;
    logic [RANGE_W-1:0]  range_w;
    logic                low_w;
    logic                high_w;
    logic                too_few_w;
    logic                flat_w;
    logic [RANGE_W-1:0]  mul_a;
    logic [LEVEL_W-1:0]  mul_b;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_start;
    logic [QUOT_W-1:0]   quot;
    logic                div_more;
    logic                out_full;
    logic                do_write;
    logic [SAMPLE_W-1:0] value_w;

    // Effective level count: 0 acts as 1, clamped to the maximum
    always_comb begin
        if (levels_reg == '0) begin
            lvl = LEVEL_W'(1);
        end else if (levels_reg > LEVEL_W'(MAX_LEVELS)) begin
            lvl = LEVEL_W'(MAX_LEVELS);
        end else begin
            lvl = levels_reg;
        end
        lvl_m1 = lvl - 1'b1;
    end

    // Classification of the sample against the measured range
    always_comb begin
        diff_w    = {x_reg[SAMPLE_W-1], x_reg} - {min_reg[SAMPLE_W-1], min_reg};
        range_w   = {max_reg[SAMPLE_W-1], max_reg} - {min_reg[SAMPLE_W-1], min_reg};
        low_w     = ($signed(diff_w) <= $signed(RANGE_W'(0)));
        high_w    = ($signed(diff_w) >= $signed(range_w));
        too_few_w = (count_reg < lvl);
        flat_w    = (max_reg == min_reg);
    end

    // Shared multiplier operands: d*L or index*range
    always_comb begin
        if (ctrl.action == ACT_MUL_IR) begin
            mul_a = range_reg;
            mul_b = LEVEL_W'(idx_reg);
        end else begin
            mul_a = diff_reg;
            mul_b = lvl;
        end
    end

    // Divider operands: (2dL + r) / 2r or (2*idx*r + L) / 2L
    always_comb begin
        if (ctrl.action == ACT_DIV_OFF) begin
            div_num = {prod_reg, 1'b0} + NUM_W'(lvl);
            div_den = DEN_W'({lvl, 1'b0});
        end else begin
            div_num = {prod_reg, 1'b0} + NUM_W'(range_reg);
            div_den = {range_reg, 1'b0};
        end
    end

    assign div_start = (ctrl.action == ACT_DIV_IDX) || (ctrl.action == ACT_DIV_OFF);

    mmq_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .step    (ctrl.action == ACT_DIV_STEP),
        .num     (div_num),
        .den     (div_den),
        .quot    (quot),
        .more    (div_more)
    );

    assign out_full = out_valid_reg && !out_ready;
    assign do_write = (ctrl.action == ACT_WRITE) && !out_full;

    // Level value by status
    always_comb begin
        unique case (status_reg)
            STATUS_TOO_FEW: value_w = '0;
            STATUS_FLAT:    value_w = min_reg;
            default:        value_w = min_reg + quot[SAMPLE_W-1:0];
        endcase
    end

    always_comb begin
        flags.no_input  = !in_valid;
        flags.quant     = (op_reg == OP_QUANTIZE);
        flags.special   = special_reg;
        flags.edge_case = edge_reg;
        flags.div_more  = div_more;
        flags.out_full  = out_full;
    end

    // Input beat capture
    always_ff @(posedge aclk) begin
        if (ctrl.action == ACT_ACCEPT && in_valid) begin
            op_reg    <= in_op;
            first_reg <= in_first;
            x_reg     <= in_sample;
        end
    end

    // Running min, max and count; levels register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_reg    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            count_reg  <= '0;
            levels_reg <= LEVELS_RESET;
        end else begin
            if (ctrl.action == ACT_MEASURE) begin
                if (first_reg) begin
                    min_reg   <= x_reg;
                    max_reg   <= x_reg;
                    count_reg <= COUNT_W'(1);
                end else begin
                    if ($signed(x_reg) < $signed(min_reg)) begin
                        min_reg <= x_reg;
                    end
                    if ($signed(x_reg) > $signed(max_reg)) begin
                        max_reg <= x_reg;
                    end
                    if (count_reg != COUNT_MAX) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
            if (cfg_we) begin
                levels_reg <= cfg_levels;
            end
        end
    end

    // Quantize working registers
    always_ff @(posedge aclk) begin
        unique case (ctrl.action)
            ACT_PREP: begin
                range_reg   <= range_w;
                diff_reg    <= diff_w;
                special_reg <= too_few_w || flat_w;
                edge_reg    <= low_w || high_w;
                if (too_few_w) begin
                    status_reg <= STATUS_TOO_FEW;
                end else if (flat_w) begin
                    status_reg <= STATUS_FLAT;
                end else begin
                    status_reg <= STATUS_OK;
                end
                if (too_few_w || flat_w || low_w) begin
                    idx_reg <= '0;
                end else begin
                    idx_reg <= lvl_m1[IDX_W-1:0];
                end
            end
            ACT_MUL_DL, ACT_MUL_IR: begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            ACT_IDX_Q: begin
                if (quot > QUOT_W'(lvl_m1)) begin
                    idx_reg <= lvl_m1[IDX_W-1:0];
                end else begin
                    idx_reg <= quot[IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (do_write) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            out_index_reg  <= idx_reg;
            out_value_reg  <= value_w;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

// ===== design/minmax_uniform_quantizer.sv =====
// Min/max uniform quantizer top: stream and levels ports. Uses mmq_pkg, mmq_sequencer, mmq_datapath.
// Measure beat: after acceptance the op check and the measure step run before the next beat is taken.
// Quantize beat: prep, d*L multiply, index divider pass, index*range multiply, offset divider
// pass (17-bit passes, one bit a cycle), result write; at or beyond a range end the index pass
// is skipped, and too few or flat skip both passes; a full result register holds the write.
// Synchronous active-low reset: min/max/count, levels and result valid to reset values.
`timescale 1ns / 1ps

module minmax_uniform_quantizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmq_pkg::IN_TDATA_W-1:0]      s_tdata,   // sample
    input  logic [1:0]                          s_tuser,   // op, first
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmq_pkg::OUT_TDATA_W-1:0]     m_tdata,   // level_index, level_value
    output logic [mmq_pkg::STATUS_W-1:0]        m_tuser,   // status
    // levels register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmq_pkg::LEVEL_W-1:0]         cfg_data
);
    import mmq_pkg::*;

    mmq_ctrl_t           ctrl;
    mmq_flags_t          flags;
    logic [IDX_W-1:0]    out_index;
    logic [SAMPLE_W-1:0] out_value;

    // No beat is taken while in reset
    assign s_tready  = aresetn && (ctrl.action == ACT_ACCEPT);
    assign cfg_ready = aresetn;
    assign m_tdata   = OUT_TDATA_W'({out_value, out_index});

    mmq_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    mmq_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .flags      (flags),
        .in_valid   (s_tvalid),
        .in_op      (s_tuser[0]),
        .in_first   (s_tuser[1]),
        .in_sample  (s_tdata[SAMPLE_W-1:0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_levels (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_value  (out_value),
        .out_status (m_tuser)
    );

endmodule

// ===== design/mmq_checker.sv =====
// mmq_checker: port-level checks of the quantizer, bound to the top level.
// Depends on mmq_pkg.
`timescale 1ns / 1ps

module mmq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mmq_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [mmq_pkg::STATUS_W-1:0]    m_tuser
);
    import mmq_pkg::*;

    // A held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Status never takes the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_TOO_FEW ||
                      m_tuser == STATUS_FLAT))
        else $error("undefined status code");

    // Too few samples gives an all-zero level
    a_too_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_TOO_FEW |-> m_tdata == '0)
        else $error("too_few result not zero");

    // Flat range gives index zero
    a_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_FLAT |-> m_tdata[IDX_W-1:0] == '0)
        else $error("flat range index not zero");

    // One beat at a time: no acceptance in the cycle after one
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back input acceptance");

endmodule

bind minmax_uniform_quantizer mmq_checker u_mmq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
